/* rtl/apse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apse_pkg
// Types and constants for the Annex-B parameter-set extractor.
// ----------------------------------------------------------------------------
package apse_pkg;

    localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
    localparam logic [4:0] NAL_TYPE_PPS = 5'd8;

    localparam logic KIND_SPS = 1'b0;
    localparam logic KIND_PPS = 1'b1;

    // Most result transfers one input byte can cause.
    localparam int MAX_RES = 4;

    // Output queue; depth must be a power of two and at least MAX_RES.
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [7:0] data;
        logic       kind;
        logic       last;
    } apse_entry_t;

endpackage : apse_pkg
`default_nettype wire

/* rtl/annexb_parameter_set_extractor.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// annexb_parameter_set_extractor
// Scans an Annex-B byte stream for 00 00 01 start codes and forwards the first
// SPS and the first PPS unit after reset or forget_saved, last byte of each unit flagged.
//
// channel  dir  tdata (low bit up)                  tlast      tuser
// s_       in   in_byte[7:0], forget_saved[8], pad  frame_end  -
// m_       out  out_byte[7:0]                       unit_last  unit_kind
//
// One input byte per cycle; the scan and start-code logic is one registered
// pass, and up to four result transfers per byte go into an 8-entry queue.
// s_tready drops while the queue holds more than four entries.
// m_ drains the queue one transfer per cycle; stalls on m_ back up into s_.
// Synchronous active-low reset clears the scan state, seen flags and queue.
// ----------------------------------------------------------------------------
module annexb_parameter_set_extractor
    import apse_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] in_byte, [8] forget_saved, zero pad
    input  wire logic        s_tlast,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast,
    output logic [0:0]       m_tuser    // [0] unit_kind
);

    logic [1:0]  zero_run_reg, zero_run_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        held_valid_reg, held_valid_next;
    logic        capturing_reg, capturing_next;
    logic        capture_kind_reg, capture_kind_next;
    logic        expect_header_reg, expect_header_next;
    logic        seen_sps_reg, seen_sps_next;
    logic        seen_pps_reg, seen_pps_next;

    apse_entry_t       q_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_reg, rd_reg;
    logic [Q_AW:0]     count_reg;

    logic [7:0]        res_byte [MAX_RES];
    logic [MAX_RES-1:0] res_last;
    logic [2:0]        res_n;

    logic s_hs, m_hs;
    logic [7:0] b;
    logic fe, fg;

    assign b  = s_tdata[7:0];
    assign fg = s_tdata[8];
    assign fe = s_tlast;

    assign s_tready = (count_reg <= (Q_AW+1)'(Q_DEPTH - MAX_RES));
    assign s_hs     = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_hs     = m_tvalid && m_tready;

    assign m_tdata    = q_reg[rd_reg].data;
    assign m_tlast    = q_reg[rd_reg].last;
    assign m_tuser[0] = q_reg[rd_reg].kind;

    always_comb begin
        logic [1:0] zr;
        logic [7:0] hb;
        logic       hv, cap, kind, exph, sps, pps;

        zr   = zero_run_reg;
        hb   = held_byte_reg;
        hv   = held_valid_reg;
        cap  = capturing_reg;
        kind = capture_kind_reg;
        exph = expect_header_reg;
        sps  = seen_sps_reg;
        pps  = seen_pps_reg;

        res_byte = '{default: '0};
        res_last = '0;
        res_n    = '0;

        if (fg) begin
            sps = 1'b0;
            pps = 1'b0;
        end

        if (exph) begin
            exph = 1'b0;
            if (b[4:0] == NAL_TYPE_SPS && !sps) begin
                sps  = 1'b1;
                cap  = 1'b1;
                kind = KIND_SPS;
            end else if (b[4:0] == NAL_TYPE_PPS && !pps) begin
                pps  = 1'b1;
                cap  = 1'b1;
                kind = KIND_PPS;
            end
            if (cap) begin
                hb = b;
                hv = 1'b1;
                zr = 2'd0;
                if (fe) begin
                    res_byte[res_n[1:0]] = b;
                    res_last[res_n[1:0]] = 1'b1;
                    res_n = res_n + 3'd1;
                    hv = 1'b0;
                end
            end else begin
                zr = (b == 8'h00) ? 2'd1 : 2'd0;
            end
        end else if (cap) begin
            if (b == 8'h00) begin
                if (zr == 2'd2) begin
                    if (hv) begin
                        res_byte[res_n[1:0]] = hb;
                        res_last[res_n[1:0]] = 1'b0;
                        res_n = res_n + 3'd1;
                    end
                    hb = 8'h00;
                    hv = 1'b1;
                end else begin
                    zr = zr + 2'd1;
                end
                if (fe) begin
                    if (hv) begin
                        res_byte[res_n[1:0]] = hb;
                        res_last[res_n[1:0]] = (zr == 2'd0);
                        res_n = res_n + 3'd1;
                    end
                    if (zr != 2'd0) begin
                        res_byte[res_n[1:0]] = 8'h00;
                        res_last[res_n[1:0]] = (zr == 2'd1);
                        res_n = res_n + 3'd1;
                    end
                    if (zr == 2'd2) begin
                        res_byte[res_n[1:0]] = 8'h00;
                        res_last[res_n[1:0]] = 1'b1;
                        res_n = res_n + 3'd1;
                    end
                    hv = 1'b0;
                    zr = 2'd0;
                end
            end else if (b == 8'h01 && zr == 2'd2) begin
                if (hv) begin
                    res_byte[res_n[1:0]] = hb;
                    res_last[res_n[1:0]] = 1'b1;
                    res_n = res_n + 3'd1;
                end
                hv   = 1'b0;
                cap  = 1'b0;
                zr   = 2'd0;
                exph = 1'b1;
            end else begin
                // pending bytes are confirmed by a non-start-code byte
                if (hv) begin
                    res_byte[res_n[1:0]] = hb;
                    res_last[res_n[1:0]] = 1'b0;
                    res_n = res_n + 3'd1;
                end
                if (zr != 2'd0) begin
                    res_byte[res_n[1:0]] = 8'h00;
                    res_last[res_n[1:0]] = 1'b0;
                    res_n = res_n + 3'd1;
                end
                if (zr == 2'd2) begin
                    res_byte[res_n[1:0]] = 8'h00;
                    res_last[res_n[1:0]] = 1'b0;
                    res_n = res_n + 3'd1;
                end
                zr = 2'd0;
                hb = b;
                hv = 1'b1;
                if (fe) begin
                    res_byte[res_n[1:0]] = b;
                    res_last[res_n[1:0]] = 1'b1;
                    res_n = res_n + 3'd1;
                    hv = 1'b0;
                end
            end
        end else begin
            if (b == 8'h00) begin
                if (zr != 2'd2) begin
                    zr = zr + 2'd1;
                end
            end else if (b == 8'h01 && zr == 2'd2) begin
                exph = 1'b1;
                zr   = 2'd0;
            end else begin
                zr = 2'd0;
            end
        end

        if (fe) begin
            zr   = 2'd0;
            hv   = 1'b0;
            cap  = 1'b0;
            exph = 1'b0;
        end

        zero_run_next      = zr;
        held_byte_next     = hb;
        held_valid_next    = hv;
        capturing_next     = cap;
        capture_kind_next  = kind;
        expect_header_next = exph;
        seen_sps_next      = sps;
        seen_pps_next      = pps;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_run_reg      <= '0;
            held_valid_reg    <= 1'b0;
            capturing_reg     <= 1'b0;
            capture_kind_reg  <= 1'b0;
            expect_header_reg <= 1'b0;
            seen_sps_reg      <= 1'b0;
            seen_pps_reg      <= 1'b0;
        end else if (s_hs) begin
            zero_run_reg      <= zero_run_next;
            held_valid_reg    <= held_valid_next;
            capturing_reg     <= capturing_next;
            capture_kind_reg  <= capture_kind_next;
            expect_header_reg <= expect_header_next;
            seen_sps_reg      <= seen_sps_next;
            seen_pps_reg      <= seen_pps_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_hs) begin
            held_byte_reg <= held_byte_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_hs) begin
            for (int i = 0; i < MAX_RES; i++) begin
                if (3'(i) < res_n) begin
                    q_reg[wr_reg + Q_AW'(i)] <= '{data: res_byte[i],
                                                  kind: capture_kind_next,
                                                  last: res_last[i]};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (s_hs) begin
                wr_reg <= wr_reg + Q_AW'(res_n);
            end
            if (m_hs) begin
                rd_reg <= rd_reg + Q_AW'(1);
            end
            count_reg <= count_reg
                         + (s_hs ? (Q_AW+1)'(res_n) : '0)
                         - (m_hs ? (Q_AW+1)'(1) : '0);
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (Q_AW+1)'(Q_DEPTH))
        else $error("output queue overflow");

    a_zero_run_range: assert property (@(posedge aclk) disable iff (!aresetn)
        zero_run_reg != 2'd3)
        else $error("zero run out of range");

    a_held_in_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        held_valid_reg |-> capturing_reg)
        else $error("held byte outside a unit");

    a_header_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        expect_header_reg |-> (!capturing_reg && !held_valid_reg && zero_run_reg == 2'd0))
        else $error("header expected with scan state pending");

    a_frame_end_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=>
            (!capturing_reg && !expect_header_reg && !held_valid_reg && zero_run_reg == 2'd0))
        else $error("scan state not cleared at frame end");

endmodule : annexb_parameter_set_extractor
`default_nettype wire

/* tb/sv/annexb_parameter_set_extractor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_parameter_set_extractor_tb
// Self-checking bench for the Annex-B parameter-set extractor. Byte frames
// go in on s_. A cycle-free model of the start-code scan predicts the SPS and
// PPS bytes that must come out on m_, and every m_ transfer is checked in
// order against that prediction. Directed frames come first, then random
// frames of start codes, headers and biased payload, with random idle bursts
// on both channels, a long m_ stall and drains between phases.
// ----------------------------------------------------------------------------
module annexb_parameter_set_extractor_tb;
    import apse_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 55;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [7:0] in_byte, [8] forget_saved, zero pad
    logic        s_tlast  = 1'b0;   // frame_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [7:0] out_byte
    logic        m_tlast;           // unit_last
    logic [0:0]  m_tuser;           // [0] unit_kind

    annexb_parameter_set_extractor i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // scan model state
    logic [1:0]  zero_cnt    = '0;
    logic [7:0]  pend_byte   = '0;
    logic        pend_valid  = 1'b0;
    logic        in_unit     = 1'b0;
    logic        unit_kind   = KIND_SPS;
    logic        hdr_next    = 1'b0;
    logic        have_sps    = 1'b0;
    logic        have_pps    = 1'b0;

    apse_entry_t expected_ps_bytes[$];
    apse_entry_t want;
    logic [7:0]  frame_buf[$];

    int          errors       = 0;
    int          items_sent   = 0;
    int          cycle_count  = 0;
    bit          idle_on      = 1'b1;
    int unsigned hold_request = 0;
    int unsigned hold_left    = 0;
    int unsigned stall_left   = 0;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    task automatic push_unit_byte(input logic [7:0] b, input logic last);
        apse_entry_t e;
        e.data = b;
        e.kind = unit_kind;
        e.last = last;
        expected_ps_bytes.push_back(e);
    endtask

    // held byte first, then the pending zeros
    task automatic flush_pending(input logic final_flag);
        int total;
        int k;
        total = int'(pend_valid) + int'(zero_cnt);
        k = 0;
        if (pend_valid) begin
            k++;
            push_unit_byte(pend_byte, final_flag && k == total);
        end
        while (k < total) begin
            k++;
            push_unit_byte(8'h00, final_flag && k == total);
        end
        pend_valid = 1'b0;
        zero_cnt   = '0;
    endtask

    task automatic predict_extract(input logic [7:0] b, input logic fe, input logic fg);
        if (fg) begin
            have_sps = 1'b0;
            have_pps = 1'b0;
        end
        if (hdr_next) begin
            hdr_next = 1'b0;
            if (b[4:0] == NAL_TYPE_SPS && !have_sps) begin
                have_sps  = 1'b1;
                in_unit   = 1'b1;
                unit_kind = KIND_SPS;
            end else if (b[4:0] == NAL_TYPE_PPS && !have_pps) begin
                have_pps  = 1'b1;
                in_unit   = 1'b1;
                unit_kind = KIND_PPS;
            end
            if (in_unit) begin
                pend_byte  = b;
                pend_valid = 1'b1;
                zero_cnt   = '0;
                if (fe) flush_pending(1'b1);
            end else begin
                zero_cnt = (b == 8'h00) ? 2'd1 : 2'd0;
            end
        end else if (in_unit) begin
            if (b == 8'h00) begin
                if (zero_cnt >= 2) begin
                    if (pend_valid) push_unit_byte(pend_byte, 1'b0);
                    pend_byte  = 8'h00;
                    pend_valid = 1'b1;
                end else begin
                    zero_cnt = zero_cnt + 2'd1;
                end
                if (fe) flush_pending(1'b1);
            end else if (b == 8'h01 && zero_cnt >= 2) begin
                if (pend_valid) push_unit_byte(pend_byte, 1'b1);
                pend_valid = 1'b0;
                in_unit    = 1'b0;
                zero_cnt   = '0;
                hdr_next   = 1'b1;
            end else begin
                flush_pending(1'b0);
                pend_byte  = b;
                pend_valid = 1'b1;
                if (fe) flush_pending(1'b1);
            end
        end else begin
            if (b == 8'h00) begin
                if (zero_cnt < 2) zero_cnt = zero_cnt + 2'd1;
            end else if (b == 8'h01 && zero_cnt >= 2) begin
                hdr_next = 1'b1;
                zero_cnt = '0;
            end else begin
                zero_cnt = '0;
            end
        end
        if (fe) begin
            zero_cnt   = '0;
            pend_valid = 1'b0;
            in_unit    = 1'b0;
            hdr_next   = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_ps_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer data=%02h kind=%0d last=%0d",
                         $time, m_tdata, m_tuser[0], m_tlast);
            end else begin
                want = expected_ps_bytes.pop_front();
                if (m_tdata !== want.data) begin
                    errors++;
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.data, m_tdata);
                end
                if (m_tuser[0] !== want.kind) begin
                    errors++;
                    $display("%0t: unit_kind expected %0d actual %0d",
                             $time, want.kind, m_tuser[0]);
                end
                if (m_tlast !== want.last) begin
                    errors++;
                    $display("%0t: unit_last expected %0d actual %0d",
                             $time, want.last, m_tlast);
                end
            end
        end
    end

    // receiver: long hold on request, otherwise random stall bursts
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic fe, input logic fg);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, fg, b};
        s_tlast  <= fe;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_extract(b, fe, fg);
        items_sent++;
    endtask

    task automatic send_frame(input int forget_at);
        for (int i = 0; i < frame_buf.size(); i++) begin
            send_byte(frame_buf[i], i == frame_buf.size() - 1, i == forget_at);
        end
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (expected_ps_bytes.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] biased_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r < 2) return 8'h00;
        if (r == 2) return 8'h01;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] random_header();
        int r;
        logic [2:0] hi;
        r  = $urandom_range(0, 9);
        hi = 3'($urandom_range(0, 7));
        if (r < 4) return {hi, NAL_TYPE_SPS};
        if (r < 8) return {hi, NAL_TYPE_PPS};
        return biased_byte();
    endfunction

    task automatic build_random_frame();
        int units;
        int len;
        frame_buf.delete();
        if ($urandom_range(0, 5) == 0) begin
            // broken stream: biased noise only
            len = $urandom_range(4, 12);
            repeat (len) frame_buf.push_back(biased_byte());
            return;
        end
        if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(1, 3);
            repeat (len) frame_buf.push_back(biased_byte());
        end
        units = $urandom_range(1, 3);
        repeat (units) begin
            if ($urandom_range(0, 3) == 0) frame_buf.push_back(8'h00);
            frame_buf.push_back(8'h00);
            frame_buf.push_back(8'h00);
            frame_buf.push_back(8'h01);
            frame_buf.push_back(random_header());
            len = $urandom_range(0, 6);
            repeat (len) frame_buf.push_back(biased_byte());
        end
        if ($urandom_range(0, 5) == 0) begin
            frame_buf.push_back(8'h00);
            frame_buf.push_back(8'h00);
            frame_buf.push_back(8'h01);
        end
    endtask

    task automatic send_random_frames(input int n_items);
        int start;
        int forget_at;
        start = items_sent;
        while (items_sent - start < n_items) begin
            build_random_frame();
            forget_at = ($urandom_range(0, 2) == 0) ?
                        $urandom_range(0, frame_buf.size() - 1) : -1;
            send_frame(forget_at);
        end
    endtask

    // leading junk, SPS closed by a four-byte start code, PPS, start code at frame end
    task automatic test_first_parameter_sets();
        frame_buf = '{8'h55, 8'h00, 8'h00, 8'h01, 8'h67, 8'hFF, 8'h00, 8'h00,
                      8'h00, 8'h01, 8'h68, 8'h80, 8'h00, 8'h00, 8'h01};
        send_frame(-1);
        wait_results_done();
    endtask

    // repeated SPS skipped; clear on a PPS header that ends the frame
    task automatic test_repeat_and_clear();
        frame_buf = '{8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01, 8'h28};
        send_frame(7);
        wait_results_done();
    endtask

    // trailing zeros held back and closed by the frame end
    task automatic test_zeros_at_frame_end();
        frame_buf = '{8'h00, 8'h00, 8'h01, 8'hE7, 8'h00, 8'h00};
        send_frame(-1);
        wait_results_done();
    endtask

    // m_ held off while a long SPS streams in, so s_tready must drop
    task automatic test_output_backpressure();
        frame_buf = '{8'h00, 8'h00, 8'h01, 8'h27};
        repeat (24) frame_buf.push_back(8'($urandom_range(2, 255)));
        hold_request = 150;
        send_frame(0);
        wait_results_done();
    endtask

    task automatic test_random_frames();
        send_random_frames(RANDOM_ITEMS - 30);
        wait_results_done();
    endtask

    task automatic test_random_no_idle();
        idle_on = 1'b0;
        send_random_frames(30);
        wait_results_done();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_first_parameter_sets();
        test_repeat_and_clear();
        test_zeros_at_frame_end();
        test_output_backpressure();
        test_random_frames();
        test_random_no_idle();
        repeat (20) @(posedge aclk);
        if (errors == 0 && expected_ps_bytes.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
